/* src/sapu_pkg.sv */
package sapu_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FIELD_W         = 32;
   localparam int POWER_W         = 32;
   localparam int INDEX_W         = 6;
   localparam int ITER_W          = 7;
   localparam int STEP_LIMIT      = 4;
   localparam int STEP_W          = 3;

   localparam logic [POWER_W-1:0] ONE_Q2_30 = 32'h4000_0000;
   localparam logic [POWER_W-1:0] POWER_MAX = 32'hFFFF_FFFF;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write;
      logic start;
      logic step;
      logic next_k;
   } ctrl_type;

   typedef struct packed {
      logic n_small;
      logic can_step;
      logic overflow;
      logic k_last;
   } status_type;

endpackage

/* src/sapu_ctrl.sv */
module sapu_ctrl
   import sapu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_command,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_command == CMD_COMPUTE) begin
               state_in = status.n_small ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.can_step) begin
               if (status.overflow) begin
                  state_in = ST_DONE;
               end
            end else if (status.k_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctrl.write = req_valid && req_command == CMD_LOAD;
            ctrl.start = req_valid && req_command == CMD_COMPUTE;
         end
         ST_FETCH: begin
         end
         ST_STEP: begin
            ctrl.step   = status.can_step;
            ctrl.next_k = !status.can_step && !status.k_last;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* src/sapu_datapath.sv */
module sapu_datapath
   import sapu_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
)
(
   input  logic               clock,
   input  logic [INDEX_W-1:0] req_table_index,
   input  logic [FIELD_W-1:0] req_table_value,
   input  logic [FIELD_W-1:0] req_x_value,
   input  logic [ITER_W-1:0]  req_iterations,
   output logic [POWER_W-1:0] rsp_power_value,
   input  ctrl_type           ctrl,
   output status_type         status
);

   localparam int WORD_W = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KW     = $clog2(TABLE_DEPTH + 1);

   logic [WORD_W-1:0]  table_mem [TABLE_DEPTH];
   logic [WORD_W-1:0]  rd_ff;
   logic [WORD_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]  t_ff, t_in;
   logic [POWER_W-1:0] e_ff, e_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      n_ff, n_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;

   logic [WORD_W-1:0]  remain;
   logic [POWER_W:0]   step_sum;
   logic [KW-1:0]      k_next;
   logic [KW-1:0]      n_clamped;

   always_ff @(posedge clock) begin
      if (ctrl.write && {1'b0, req_table_index} < ITER_W'(TABLE_DEPTH)) begin
         table_mem[req_table_index[AW-1:0]] <= req_table_value[WORD_W-1:0];
      end
      rd_ff <= table_mem[k_ff[AW-1:0]];
   end

   assign n_clamped = (req_iterations > ITER_W'(TABLE_DEPTH)) ? KW'(TABLE_DEPTH)
                                                              : KW'(req_iterations);
   assign remain    = x_ff - t_ff;
   assign step_sum  = {1'b0, e_ff} + {1'b0, e_ff >> k_ff};
   assign k_next    = k_ff + KW'(1);

   assign status.n_small  = n_clamped <= KW'(1);
   assign status.can_step = rd_ff != '0 && steps_ff != STEP_W'(STEP_LIMIT) && rd_ff <= remain;
   assign status.overflow = step_sum[POWER_W];
   assign status.k_last   = k_next >= n_ff;

   always_comb begin
      x_in     = x_ff;
      t_in     = t_ff;
      e_in     = e_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      steps_in = steps_ff;
      priority if (ctrl.start) begin
         x_in     = req_x_value[WORD_W-1:0];
         t_in     = '0;
         e_in     = ONE_Q2_30;
         k_in     = KW'(1);
         n_in     = n_clamped;
         steps_in = '0;
      end else if (ctrl.step) begin
         t_in     = t_ff + rd_ff;
         e_in     = step_sum[POWER_W] ? POWER_MAX : step_sum[POWER_W-1:0];
         steps_in = steps_ff + STEP_W'(1);
      end else if (ctrl.next_k) begin
         k_in     = k_next;
         steps_in = '0;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      t_ff     <= t_in;
      e_ff     <= e_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      steps_ff <= steps_in;
   end

   assign rsp_power_value = e_ff;

endmodule

/* src/shift_add_power_unit_top.sv */
// Load: one transfer a cycle, no result.
// Compute: the result is transferred after a fetch and step phase for each k = 1..n-1,
// with at most STEP_LIMIT additions per k, plus any response stall; an overflow or n <= 1
// goes straight to the result, and the next request is taken in the cycle after the result transfer.
// The step loop runs one compare-add-shift per cycle against one registered table read.
// Synchronous active-high reset returns the controller to idle; the table is not cleared.
module shift_add_power_unit_top
   import sapu_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [INDEX_W-1:0] req_table_index,
   input  logic [FIELD_W-1:0] req_table_value,
   input  logic [FIELD_W-1:0] req_x_value,
   input  logic [ITER_W-1:0]  req_iterations,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [POWER_W-1:0] rsp_power_value
);

   ctrl_type   ctrl;
   status_type status;

   sapu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .ctrl        (ctrl)
   );

   sapu_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_x_value     (req_x_value),
      .req_iterations  (req_iterations),
      .rsp_power_value (rsp_power_value),
      .ctrl            (ctrl),
      .status          (status)
   );

endmodule

/* sim/shift_add_power_unit_checker.sv */
`timescale 1ns / 1ps

module shift_add_power_unit_checker
   import sapu_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_command,
   input  logic [INDEX_W-1:0] req_table_index,
   input  logic [FIELD_W-1:0] req_table_value,
   input  logic [FIELD_W-1:0] req_x_value,
   input  logic [ITER_W-1:0]  req_iterations,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [POWER_W-1:0] rsp_power_value,
   output int                 fail_count,
   output int                 pending
);

   localparam logic [POWER_W-1:0] UNITY     = 32'h4000_0000;
   localparam logic [POWER_W-1:0] SATURATED = 32'hFFFF_FFFF;
   localparam int                 ADD_CAP   = 4;

   typedef struct packed {
      logic [FIELD_W-1:0] x;
      logic [ITER_W-1:0]  n;
      logic [POWER_W-1:0] power;
   } power_job_type;

   logic [FIELD_W-1:0] log_words [TABLE_DEPTH];
   power_job_type      expected_powers [$];
   power_job_type      job;
   int                 mismatch_total = 0;

   // greedy shift-and-add: e *= (1 + 2^-k), at most ADD_CAP times per k, while the log sum stays within x; saturates
   function automatic logic [POWER_W-1:0] predict_power(logic [FIELD_W-1:0] x,
                                                        logic [ITER_W-1:0] n);
      logic [63:0] arg;
      logic [63:0] sum;
      logic [63:0] acc;
      logic [63:0] entry;
      int          last;
      int          k;
      int          adds;
      arg  = {32'b0, x};
      last = (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
      sum  = '0;
      acc  = {32'b0, UNITY};
      for (k = 1; k < last; k++) begin
         entry = {32'b0, log_words[k]};
         adds  = 0;
         while (entry != 0 && adds < ADD_CAP && entry <= arg - sum) begin
            sum = sum + entry;
            acc = acc + (acc >> k);
            adds++;
            if (acc > {32'b0, SATURATED})
               return SATURATED;
         end
      end
      return acc[POWER_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               if (mismatch_total < 10)
                  $display("unexpected power transfer: got %h", rsp_power_value);
               mismatch_total++;
            end else begin
               job = expected_powers.pop_front();
               if (rsp_power_value !== job.power) begin
                  if (mismatch_total < 10)
                     $display("power mismatch: x %h n %0d expected %h got %h",
                              job.x, job.n, job.power, rsp_power_value);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_LOAD) begin
               if (req_table_index < TABLE_DEPTH)
                  log_words[req_table_index] = req_table_value;
            end else begin
               job.x     = req_x_value;
               job.n     = req_iterations;
               job.power = predict_power(req_x_value, req_iterations);
               expected_powers.push_back(job);
            end
         end
      end
      fail_count <= mismatch_total;
      pending    <= expected_powers.size();
   end

endmodule

/* sim/shift_add_power_unit_top_test.sv */
`timescale 1ns / 1ps

module shift_add_power_unit_top_test;
   import sapu_pkg::*;

   typedef enum logic [1:0] {
      TAB_SOUND,
      TAB_NUDGED,
      TAB_TINY,
      TAB_WILD
   } table_style_type;

   localparam int ITEM_TARGET = 1050;
   localparam int GAP_MAX     = 18;
   localparam int TOP_ENTRY   = TABLE_DEPTH_DEF - 1;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_command     = CMD_LOAD;
   logic [INDEX_W-1:0] req_table_index = '0;
   logic [FIELD_W-1:0] req_table_value = '0;
   logic [FIELD_W-1:0] req_x_value     = '0;
   logic [ITER_W-1:0]  req_iterations  = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [POWER_W-1:0] rsp_power_value;

   int  fail_count;
   int  pending;
   int  sent      = 0;
   int  filled    = 0;
   bit  written [TABLE_DEPTH_DEF];
   bit  burst     = 1'b0;
   bit  rsp_calm  = 1'b0;
   int  rsp_hold  = 0;
   int  next_hold;

   shift_add_power_unit_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_x_value     (req_x_value),
      .req_iterations  (req_iterations),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_power_value (rsp_power_value)
   );

   shift_add_power_unit_checker power_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_x_value     (req_x_value),
      .req_iterations  (req_iterations),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_power_value (rsp_power_value),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if ((rsp_valid && !rsp_stall) || $urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 15) == 0)
            rsp_calm <= !rsp_calm;
         next_hold = rsp_calm ? 0 : $urandom_range(0, GAP_MAX);
         rsp_hold  <= next_hold;
         rsp_stall <= (next_hold != 0);
      end else begin
         rsp_hold  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   // log_b(1 + 2^-k) in unsigned Q8.24
   function automatic logic [FIELD_W-1:0] log_word(real base, int k);
      real y;
      y = 1.0;
      repeat (k) y = y / 2.0;
      if (k > 20)
         return $rtoi(y / $ln(base) * 16777216.0 + 0.5);
      return $rtoi($ln(1.0 + y) / $ln(base) * 16777216.0 + 0.5);
   endfunction

   task automatic send_item(logic cmd, logic [INDEX_W-1:0] idx, logic [FIELD_W-1:0] word,
                            logic [FIELD_W-1:0] x, logic [ITER_W-1:0] n);
      int gap;
      gap = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_table_index <= idx;
      req_table_value <= word;
      req_x_value     <= x;
      req_iterations  <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (cmd == CMD_LOAD) begin
         written[idx] = 1'b1;
         while (filled < TOP_ENTRY && written[filled + 1]) filled++;
      end
   endtask

   task automatic load_word(logic [INDEX_W-1:0] idx, logic [FIELD_W-1:0] word);
      send_item(CMD_LOAD, idx, word, $urandom(), ITER_W'($urandom_range(0, 127)));
   endtask

   task automatic run_power(logic [FIELD_W-1:0] x, logic [ITER_W-1:0] n);
      send_item(CMD_COMPUTE, INDEX_W'($urandom_range(0, 63)), $urandom(), x, n);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      table_style_type    style;
      real                base;
      int                 span;
      int                 m;
      int                 n;
      int                 k;
      int                 pick;
      logic [FIELD_W-1:0] word;
      logic [FIELD_W-1:0] x;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (k = 1; k <= 6; k++)
         load_word(INDEX_W'(k), log_word(2.0, k));
      load_word(0, 32'hFFFF_FFFF);
      load_word(INDEX_W'(TOP_ENTRY), 32'h0000_0000);
      run_power(32'hFFFF_FFFF, 0);
      run_power(32'hFFFF_FFFF, 1);
      run_power(32'h0000_0000, 7);
      run_power(32'hFFFF_FFFF, 7);
      run_power($rtoi($ln(3.0) / $ln(2.0) * 16777216.0), 7);
      load_word(3, 32'h0000_0000);
      run_power(32'h00E6_6666, 7);
      load_word(2, 32'h0000_0001);
      run_power(32'h0100_0000, 4);
      wait_for_results();

      while (sent < ITEM_TARGET) begin
         pick  = $urandom_range(0, 19);
         style = (pick < 10) ? TAB_SOUND : (pick < 14) ? TAB_NUDGED :
                 (pick < 17) ? TAB_TINY : TAB_WILD;
         base  = 1.1 + $urandom_range(0, 1890) / 100.0;
         span  = $rtoi($ln(4.0) / $ln(base) * 16777216.0 * 1.25);
         burst = ($urandom_range(0, 3) == 0);
         m     = (filled < TOP_ENTRY || $urandom_range(0, 3) == 0) ?
                 TOP_ENTRY : $urandom_range(1, 16);
         for (k = 1; k <= m; k++) begin
            case (style)
               TAB_SOUND: begin
                  word = log_word(base, k);
               end
               TAB_NUDGED: begin
                  word = log_word(base, k) + $urandom_range(0, 512) - 256;
               end
               TAB_TINY: begin
                  word = $urandom_range(1, 16);
               end
               default: begin
                  word = $urandom();
               end
            endcase
            if ($urandom_range(0, 15) == 0)
               word = '0;
            load_word(INDEX_W'(k), word);
         end
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               n = $urandom_range(0, (filled + 1 < 12) ? filled + 1 : 12);
            else if (pick < 9 || filled < TOP_ENTRY)
               n = $urandom_range(0, filled + 1);
            else
               n = $urandom_range(TABLE_DEPTH_DEF, 127);
            pick = $urandom_range(0, 15);
            if (pick == 0)
               x = '0;
            else if (pick == 1)
               x = '1;
            else if (pick < 4)
               x = $urandom();
            else
               x = $urandom_range(0, span);
            run_power(x, ITER_W'(n));
         end
         // stray loads over the whole table, index zero included
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               load_word(INDEX_W'($urandom_range(0, 63)), $urandom());
         if ($urandom_range(0, 5) == 0)
            wait_for_results();
      end

      wait_for_results();
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
